@@ rtl/modular_exponentiation_unit_defines.svh @@
// ----------------------------------------------------------------------------
// modular exponentiation unit assertion macros
// shared property forms for the port checkers of the block
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MODEXP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MODEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// modexp_pkg
// widths and interface types shared by the modular exponentiation modules
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

    // bits of exponent and modulus that take part in the arithmetic
    localparam int OPERAND_WIDTH = 31;
    // fixed field widths of the ports
    localparam int BASE_W  = 32;
    localparam int FIELD_W = 31;
    localparam int RES_W   = 31;

    // bit counter of the shared unit must hold BASE_W itself
    localparam int CNT_W = $clog2(BASE_W + 1);
    // index into the exponent bits
    localparam int IDX_W = $clog2(OPERAND_WIDTH);

    // command to the shared modular multiply unit
    typedef struct packed {
        logic                     start;
        logic [BASE_W-1:0]        opx;
        logic [CNT_W-1:0]         nbits;
        logic [OPERAND_WIDTH-1:0] opy;
    } mm_cmd_t;

    // status back from the shared unit
    typedef struct packed {
        logic                     done;
        logic [OPERAND_WIDTH-1:0] result;
    } mm_stat_t;

endpackage

`default_nettype wire

@@ rtl/modular_exponentiation_unit.sv @@
// zero modulus flags an error with no arithmetic; zero base or zero exponent stop after
// the base reduction; otherwise 31 squares plus one multiply per set exponent bit
// every square and multiply runs 31 steps of the one bit-serial mulmod unit
// one item at a time: in_stall stays high from transfer until result is queued
// asynchronous active-low reset clears sequencer and output valid; no memories
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// base^exponent mod modulus by left-to-right square and multiply
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [modexp_pkg::BASE_W-1:0]  base_value,
    input  wire logic [modexp_pkg::FIELD_W-1:0] exponent,
    input  wire logic [modexp_pkg::FIELD_W-1:0] modulus,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [modexp_pkg::RES_W-1:0]        power_residue,
    output logic                                modulus_error
);
    import modexp_pkg::*;

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE = 3'd0;  // waiting for an input transfer
    localparam logic [STATE_W-1:0] S_RED  = 3'd1;  // base magnitude mod modulus
    localparam logic [STATE_W-1:0] S_SQ   = 3'd2;  // acc = acc * acc mod m
    localparam logic [STATE_W-1:0] S_MUL  = 3'd3;  // acc = acc * b mod m
    localparam logic [STATE_W-1:0] S_DONE = 3'd4;  // result waits for output slot

    localparam int W = OPERAND_WIDTH;

    logic [STATE_W-1:0] state_reg, state_next;
    logic               go_reg,    go_next;
    logic               out_valid_reg, out_valid_next;

    logic [BASE_W-1:0] base_reg, base_next;
    logic [W-1:0]      e_reg,    e_next;
    logic [W-1:0]      m_reg,    m_next;
    logic [W-1:0]      acc_reg,  acc_next;
    logic [W-1:0]      b_reg,    b_next;
    logic [IDX_W-1:0]  idx_reg,  idx_next;
    logic [W-1:0]      res_reg,  res_next;
    logic              err_reg,  err_next;
    logic [W-1:0]      out_res_reg, out_res_next;
    logic              out_err_reg, out_err_next;

    mm_cmd_t  mm_cmd;
    mm_stat_t mm_stat;

    logic              base_neg;
    logic [BASE_W-1:0] base_mag;
    logic [W-1:0]      base_red;
    logic              in_xfer;
    logic              out_free;

    // shared arithmetic unit, reused for the base reduction and every round
    modexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mm_cmd),
        .modulus (m_reg),
        .stat    (mm_stat)
    );

    // magnitude of the signed base; the most negative value maps onto itself
    assign base_neg = base_reg[BASE_W-1];
    assign base_mag = base_neg ? ((~base_reg) + {{(BASE_W-1){1'b0}}, 1'b1}) : base_reg;

    // negative base folds back into 0..m-1
    assign base_red = (base_neg && (mm_stat.result != '0)) ? (m_reg - mm_stat.result)
                                                            : mm_stat.result;

    assign in_xfer  = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // operand selection for the shared unit, started as each state is entered
    always_comb
    begin
        mm_cmd.start = go_reg;
        case (state_reg)
            S_RED:
            begin
                // mag * 1 mod m over all base bits gives mag mod m
                mm_cmd.opx   = base_mag;
                mm_cmd.nbits = CNT_W'(BASE_W);
                mm_cmd.opy   = W'(1);
            end
            S_MUL:
            begin
                mm_cmd.opx   = {acc_reg, {(BASE_W-W){1'b0}}};
                mm_cmd.nbits = CNT_W'(W);
                mm_cmd.opy   = b_reg;
            end
            default:
            begin
                mm_cmd.opx   = {acc_reg, {(BASE_W-W){1'b0}}};
                mm_cmd.nbits = CNT_W'(W);
                mm_cmd.opy   = acc_reg;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        go_next        = 1'b0;
        base_next      = base_reg;
        e_next         = e_reg;
        m_next         = m_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        out_res_next   = out_res_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    base_next = base_value;
                    e_next    = exponent[W-1:0];
                    m_next    = modulus[W-1:0];
                    if (modulus[W-1:0] == '0)
                    begin
                        // zero modulus: flag and give zero
                        res_next   = '0;
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = S_RED;
                        go_next    = 1'b1;
                    end
                end
            end
            S_RED:
            begin
                if (mm_stat.done)
                begin
                    if (base_red == '0)
                    begin
                        // base reduces to zero: zero for any exponent
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else if (e_reg == '0)
                    begin
                        // nonzero reduced base means m > 1, so 1 mod m is 1
                        res_next   = W'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        b_next     = base_red;
                        acc_next   = W'(1);
                        idx_next   = IDX_W'(W - 1);
                        state_next = S_SQ;
                        go_next    = 1'b1;
                    end
                end
            end
            S_SQ:
            begin
                if (mm_stat.done)
                begin
                    acc_next = mm_stat.result;
                    if (e_reg[idx_reg])
                    begin
                        state_next = S_MUL;
                        go_next    = 1'b1;
                    end
                    else if (idx_reg == '0)
                    begin
                        res_next   = mm_stat.result;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = S_SQ;
                        go_next    = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                if (mm_stat.done)
                begin
                    acc_next = mm_stat.result;
                    if (idx_reg == '0)
                    begin
                        res_next   = mm_stat.result;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = S_SQ;
                        go_next    = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                // output register takes the result once its slot is empty or draining
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        e_reg       <= e_next;
        m_reg       <= m_next;
        acc_reg     <= acc_next;
        b_reg       <= b_next;
        res_reg     <= res_next;
        err_reg     <= err_next;
        out_res_reg <= out_res_next;
        out_err_reg <= out_err_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign power_residue = RES_W'(out_res_reg);
    assign modulus_error = out_err_reg;

endmodule

`default_nettype wire

@@ rtl/modexp_mulmod.sv @@
// ----------------------------------------------------------------------------
// modexp_mulmod
// bit-serial interleaved modular multiply: opx * opy mod modulus, msb first
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_mulmod (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire modexp_pkg::mm_cmd_t                  cmd,
    input  wire logic [modexp_pkg::OPERAND_WIDTH-1:0] modulus,
    output modexp_pkg::mm_stat_t                      stat
);
    import modexp_pkg::*;

    localparam int TW = OPERAND_WIDTH + 2;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg,  cnt_next;
    logic [BASE_W-1:0]        x_reg,    x_next;
    logic [OPERAND_WIDTH-1:0] r_reg,    r_next;
    logic [OPERAND_WIDTH-1:0] y_reg,    y_next;
    logic [OPERAND_WIDTH-1:0] m_reg,    m_next;

    logic [TW-1:0] addend;
    logic [TW-1:0] sum;
    logic [TW-1:0] m_one;
    logic [TW-1:0] m_two;
    logic [TW-1:0] reduced;

    // r < m and addend <= m, so the sum stays below 3m: subtracting 2m or m brings it below m
    always_comb
    begin
        addend  = x_reg[BASE_W-1] ? {2'b00, y_reg} : '0;
        sum     = {1'b0, r_reg, 1'b0} + addend;
        m_one   = {2'b00, m_reg};
        m_two   = {1'b0, m_reg, 1'b0};
        if (sum >= m_two)
        begin
            reduced = sum - m_two;
        end
        else if (sum >= m_one)
        begin
            reduced = sum - m_one;
        end
        else
        begin
            reduced = sum;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.nbits;
            x_next    = cmd.opx;
            r_next    = '0;
            y_next    = cmd.opy;
            m_next    = modulus;
        end
        else if (busy_reg)
        begin
            r_next   = reduced[OPERAND_WIDTH-1:0];
            x_next   = {x_reg[BASE_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        r_reg <= r_next;
        y_reg <= y_next;
        m_reg <= m_next;
    end

    assign stat.done   = done_reg;
    assign stat.result = r_reg;

endmodule

`default_nettype wire

@@ rtl/modexp_checker.sv @@
// ----------------------------------------------------------------------------
// modexp_checker
// port-level checks of the modular exponentiation unit, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_unit_defines.svh"

module modexp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [modexp_pkg::RES_W-1:0]  power_residue,
    input wire logic                          modulus_error
);

    // one item at a time: the block stalls right after an input transfer
    `MODEXP_ASSERT_NEXT(a_busy_after_xfer, in_valid && !in_stall, in_stall, "no stall after transfer")

    // an error result always carries zero
    `MODEXP_ASSERT_NOW(a_err_zero, out_valid && modulus_error, power_residue == '0, "residue on error")

    // a new result only shows up after the block has stalled on an item
    `MODEXP_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall), "result without work")

    // a stalled result stays offered
    `MODEXP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

bind modular_exponentiation_unit modexp_checker u_modexp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .power_residue (power_residue),
    .modulus_error (modulus_error)
);

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular exponentiation unit testbench
// drives base, exponent and modulus transfers into the unit and checks each
// residue and error flag against a square-and-multiply predictor kept here,
// first on directed corner operands, then on random operands under several
// sender gap and receiver backpressure profiles
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    // cycles without any transfer before the run is declared hung; the limit leaves
    // room for the slowest item plus a long receiver stall on top
    localparam int WATCHDOG_LIMIT = 20000;
    // quiet cycles after the last residue to catch a stray extra result
    localparam int DRAIN_CYCLES   = 64;
    // random items per idling profile, four profiles in all
    localparam int ITEMS_PER_PHASE = 390;

    // exponent and modulus bits that take part in the arithmetic
    localparam logic [63:0] OPERAND_MASK = (64'd1 << modexp_pkg::OPERAND_WIDTH) - 64'd1;

    // one expected result as it should leave the unit
    typedef struct {
        logic [modexp_pkg::RES_W-1:0] residue;
        logic                         error_flag;
    } residue_expect_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel; the signals the bench drives start at known values from time zero
    logic                           in_valid   = 1'b0;
    logic                           in_stall;
    logic [modexp_pkg::BASE_W-1:0]  base_value = '0;
    logic [modexp_pkg::FIELD_W-1:0] exponent   = '0;
    logic [modexp_pkg::FIELD_W-1:0] modulus    = '0;

    // result channel
    logic                           out_valid;
    logic                           out_stall  = 1'b0;
    logic [modexp_pkg::RES_W-1:0]   power_residue;
    logic                           modulus_error;

    // idling knobs, percent of cycles, changed between phases
    int sender_gap_pct  = 0;
    int receiver_stall_pct = 0;

    // residues still owed by the unit, oldest first
    residue_expect_t pending_residues[$];
    int              mismatch_count = 0;
    int              stuck_cycles   = 0;

    modular_exponentiation_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .base_value    (base_value),
        .exponent      (exponent),
        .modulus       (modulus),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .power_residue (power_residue),
        .modulus_error (modulus_error)
    );

    // 10 ns clock, high then low
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // expected residue of one operand set
    function automatic residue_expect_t predict_power_residue(
        input logic [modexp_pkg::BASE_W-1:0]  base_raw,
        input logic [modexp_pkg::FIELD_W-1:0] exp_raw,
        input logic [modexp_pkg::FIELD_W-1:0] mod_raw
    );
        logic [63:0]     exp_bits;
        logic [63:0]     mod_val;
        logic [63:0]     base_red;
        logic [63:0]     magnitude;
        logic [63:0]     acc;
        int              bit_idx;
        residue_expect_t prediction;
        exp_bits = {33'd0, exp_raw} & OPERAND_MASK;
        mod_val  = {33'd0, mod_raw} & OPERAND_MASK;
        // zero modulus: flag it, residue forced to zero
        if (mod_val == 64'd0)
        begin
            prediction.residue    = '0;
            prediction.error_flag = 1'b1;
            return prediction;
        end
        // negative base folded into 0 .. modulus-1
        if (base_raw[modexp_pkg::BASE_W-1])
        begin
            magnitude = {32'd0, (~base_raw) + 32'd1};
            magnitude = magnitude % mod_val;
            base_red  = (magnitude == 64'd0) ? 64'd0 : mod_val - magnitude;
        end
        else
        begin
            base_red = {32'd0, base_raw} % mod_val;
        end
        // zero base wins over zero exponent
        if (base_red == 64'd0)
        begin
            acc = 64'd0;
        end
        else
        begin
            acc = 64'd1 % mod_val;
            // left to right: square every round, multiply where the bit is set
            for (bit_idx = modexp_pkg::OPERAND_WIDTH - 1; bit_idx >= 0; bit_idx--)
            begin
                acc = (acc * acc) % mod_val;
                if (exp_bits[bit_idx])
                    acc = (acc * base_red) % mod_val;
            end
        end
        prediction.residue    = acc[modexp_pkg::RES_W-1:0];
        prediction.error_flag = 1'b0;
        return prediction;
    endfunction

    // one input transfer; returns just after the edge that accepted it with
    // in_valid still high, so the next call either reloads or lowers it once
    task automatic send_operands(
        input logic [modexp_pkg::BASE_W-1:0]  base_in,
        input logic [modexp_pkg::FIELD_W-1:0] exp_in,
        input logic [modexp_pkg::FIELD_W-1:0] mod_in
    );
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        base_value <= base_in;
        exponent   <= exp_in;
        modulus    <= mod_in;
        @(posedge clk);
        // in_stall read here is its value just before this edge
        while (in_stall !== 1'b0)
            @(posedge clk);
        pending_residues.insert(pending_residues.size(),
                                predict_power_residue(base_in, exp_in, mod_in));
    endtask

    // random operand set, weighted toward sparse exponents so most items
    // stay near the unit's shortest nonzero-exponent latency
    task automatic pick_random_operands(
        output logic [modexp_pkg::BASE_W-1:0]  base_out,
        output logic [modexp_pkg::FIELD_W-1:0] exp_out,
        output logic [modexp_pkg::FIELD_W-1:0] mod_out
    );
        int          sel;
        int          set_bits;
        logic [31:0] raw;
        longint      multiple;
        // modulus: zero, one, small, medium or full width
        sel = $urandom_range(99);
        raw = $urandom();
        if (sel < 4)
            mod_out = '0;
        else if (sel < 8)
            mod_out = 31'd1;
        else if (sel < 30)
            mod_out = 31'($urandom_range(255, 2));
        else if (sel < 50)
            mod_out = 31'($urandom_range(65535, 2));
        else
            mod_out = raw[30:0];
        // exponent: zero, dense random, or a few scattered ones
        sel = $urandom_range(99);
        raw = $urandom();
        if (sel < 6)
        begin
            exp_out = '0;
        end
        else if (sel < 16)
        begin
            exp_out = raw[30:0];
        end
        else
        begin
            exp_out  = '0;
            set_bits = $urandom_range(4, 1);
            repeat (set_bits)
                exp_out[$urandom_range(modexp_pkg::FIELD_W - 1, 0)] = 1'b1;
        end
        // base: full random, small signed, a signed multiple of the modulus,
        // or one of the field extremes
        sel = $urandom_range(99);
        if (sel < 50)
        begin
            base_out = $urandom();
        end
        else if (sel < 70)
        begin
            base_out = 32'($signed($urandom_range(600)) - 300);
        end
        else if (sel < 88)
        begin
            multiple = longint'(mod_out) * longint'($urandom_range(5, 1));
            if (multiple > 64'sd2147483647)
                multiple = longint'(mod_out);
            if ($urandom_range(1))
                multiple = -multiple;
            base_out = multiple[31:0];
        end
        else
        begin
            case ($urandom_range(3))
                0: base_out = 32'h8000_0000;
                1: base_out = 32'h7FFF_FFFF;
                2: base_out = 32'hFFFF_FFFF;
                default: base_out = 32'h0000_0000;
            endcase
        end
    endtask

    // extremes of every field, including the largest residue the unit can give
    task automatic test_field_extremes();
        send_operands(32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_operands(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFE);
        send_operands(32'hFFFF_FFFF, 31'd3,         31'h7FFF_FFFF);
        send_operands(32'h0000_0002, 31'd30,        31'h7FFF_FFFF);
        send_operands(32'h7FFF_FFFF, 31'h4000_0000, 31'h4000_0001);
        send_operands(32'h8000_0000, 31'h0000_0001, 31'h0000_0003);
        send_operands(32'h0000_0000, 31'h0000_0000, 31'h0000_0000);
    endtask

    // zero modulus, base folding to zero, zero exponent, modulus of one
    task automatic test_special_cases();
        // zero modulus with nonzero operands
        send_operands(32'd12345,     31'd5,         31'd0);
        send_operands(32'hFFFF_FFF9, 31'h7FFF_FFFF, 31'd0);
        // base that is a multiple of the modulus, positive and negative,
        // with zero exponent too since the zero base check comes first
        send_operands(32'd21,        31'd0,         31'd7);
        send_operands(32'hFFFF_FFEB, 31'd5,         31'd7);
        send_operands(32'd0,         31'd9,         31'd13);
        // zero exponent with a nonzero reduced base
        send_operands(32'd5,         31'd0,         31'd13);
        send_operands(32'hFFFF_FFFD, 31'd0,         31'd2);
        // modulus of one folds every base to zero
        send_operands(32'h8000_0000, 31'd12,        31'd1);
        send_operands(32'd7,         31'd0,         31'd1);
        // negative base folding to a nonzero residue
        send_operands(32'hFFFF_FFFD, 31'd1,         31'd10);
        send_operands(32'hFFFF_FFFF, 31'd2,         31'd2);
    endtask

    // random operands under one idling profile
    task automatic test_random_powers(input int gap_pct, input int stall_pct, input int count);
        logic [modexp_pkg::BASE_W-1:0]  rand_base;
        logic [modexp_pkg::FIELD_W-1:0] rand_exp;
        logic [modexp_pkg::FIELD_W-1:0] rand_mod;
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        repeat (count)
        begin
            pick_random_operands(rand_base, rand_exp, rand_mod);
            send_operands(rand_base, rand_exp, rand_mod);
        end
    endtask

    // receiver backpressure, redrawn every cycle from the current profile
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // result checker: every transfer out must match the oldest prediction
    always @(posedge clk)
    begin
        residue_expect_t oldest;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_residues.size() == 0)
            begin
                $error("unexpected result transfer: power_residue %0d modulus_error %0b",
                       power_residue, modulus_error);
                mismatch_count++;
            end
            else
            begin
                oldest = pending_residues.pop_front();
                if (power_residue !== oldest.residue)
                begin
                    $error("power_residue mismatch: expected %0d, actual %0d",
                           oldest.residue, power_residue);
                    mismatch_count++;
                end
                if (modulus_error !== oldest.error_flag)
                begin
                    $error("modulus_error mismatch: expected %0b, actual %0b",
                           oldest.error_flag, modulus_error);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long without a transfer on either side means a hang
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        // reset held low from time zero, then released once for the whole run
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners with no idling
        test_field_extremes();
        test_special_cases();

        // random operands: back to back, sparse sender, heavy backpressure,
        // then light idling on both sides
        test_random_powers(0,  0,  ITEMS_PER_PHASE);
        test_random_powers(88, 0,  ITEMS_PER_PHASE);
        test_random_powers(0,  88, ITEMS_PER_PHASE);
        test_random_powers(15, 15, ITEMS_PER_PHASE);

        // stop sending, let every owed residue drain, then watch for extras
        in_valid <= 1'b0;
        while (pending_residues.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
